// ===== rtl/slcm_pkg.sv =====
// Package for the seed label consistency mask: defaults, widths, codes and states.
package slcm_pkg;

  localparam int LABEL_COUNT_DEF = 65536;
  localparam int CELL_BITS_DEF   = 16;
  localparam int LABEL_W         = 16;

  // operation codes
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_MASK = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

// ===== rtl/slcm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module slcm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/seed_label_consistency_mask_core.sv =====
// Top level of the seed label consistency mask: per-seed table in RAM, scan and mask requests.
// Mask path: an accepted request is captured in the request registers and ST_LOOKUP, where
// its table entry is read; a mask result is then registered in the output register.
// A new request is taken only in ST_IDLE, not while the last one reads and writes back its entry.
// A scan request gives no result; a mask request gives exactly one.
// Reset (rst, synchronous): a clearing pass writes every table entry to zero, one per cycle;
// in_stall stays high until it ends.
module seed_label_consistency_mask_core
  import slcm_pkg::*;
#(
  parameter int LABEL_COUNT = LABEL_COUNT_DEF,
  parameter int CELL_BITS   = CELL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [LABEL_W-1:0] seed_label,
  input  logic [LABEL_W-1:0] cell_label,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LABEL_W-1:0] out_label,
  output logic               was_removed
);

  localparam int ADDR_W  = $clog2(LABEL_COUNT);
  localparam int ENTRY_W = CELL_BITS + 2;
  // entry layout: {valid, marked, first cell}
  localparam int VALID_BIT  = CELL_BITS + 1;
  localparam int MARKED_BIT = CELL_BITS;

  state_t state, state_next;

  logic [ADDR_W-1:0]    clr_addr;
  logic                 clr_done;

  // request held while its table entry is read
  logic                 req_op;
  logic [LABEL_W-1:0]   req_seed;
  logic [CELL_BITS-1:0] req_cell;
  logic                 req_hit;

  logic                 accept;
  logic                 has_entry;

  // table RAM ports
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic                 ent_valid;
  logic                 ent_marked;
  logic [CELL_BITS-1:0] ent_cell;

  logic                 load_out;

  slcm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(LABEL_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // seed zero is background; seeds at or above LABEL_COUNT have no entry
  assign has_entry = (seed_label != '0) &&
                     ({1'b0, seed_label} < (LABEL_W + 1)'(LABEL_COUNT));

  assign clr_done = (clr_addr == ADDR_W'(LABEL_COUNT - 1));

  assign ent_valid  = ram_rdata[VALID_BIT];
  assign ent_marked = ram_rdata[MARKED_BIT];
  assign ent_cell   = ram_rdata[CELL_BITS-1:0];

  // a request is taken only when the output register is empty or drains this cycle,
  // so the lookup stage always finds room for its result
  assign in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign ram_raddr = seed_label[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = req_seed[ADDR_W-1:0];
    ram_wdata  = ram_rdata;
    load_out   = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_IDLE;
        if (req_op == OP_MASK) begin
          load_out = 1'b1;
        end else if (req_hit && !ent_marked) begin
          if (!ent_valid) begin
            // first cell met by this seed
            ram_we    = 1'b1;
            ram_wdata = {1'b1, 1'b0, req_cell};
          end else if (ent_cell != req_cell) begin
            // different cell: mark for removal, the mark sticks
            ram_we    = 1'b1;
            ram_wdata = {1'b1, 1'b1, ent_cell};
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR && !clr_done) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= operation;
      req_seed <= seed_label;
      req_cell <= cell_label[CELL_BITS-1:0];
      req_hit  <= has_entry;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (req_hit && ent_marked) begin
        out_label   <= '0;
        was_removed <= 1'b1;
      end else begin
        out_label   <= req_seed;
        was_removed <= 1'b0;
      end
    end
  end

endmodule
